### design/bosf_pkg.sv
// Shared types and constants of the box overlap suppression filter.
// Used by the controller, the datapath, the overlap unit and the top level.
// No dependencies.
package bosf_pkg;

    // Fixed field widths
    localparam int CFG_BITS     = 12;
    localparam int OUT_BITS     = 12;
    localparam int CNT_OUT_BITS = 7;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    // Request kinds
    localparam logic [1:0] KIND_CAND  = 2'd0;
    localparam logic [1:0] KIND_REF   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Register indexes (word address bits)
    localparam logic [1:0] REG_IMG_W  = 2'd0;
    localparam logic [1:0] REG_IMG_H  = 2'd1;
    localparam logic [1:0] REG_BASE_W = 2'd2;

    // Register reset values
    localparam logic [CFG_BITS-1:0] IMG_W_RST  = 12'd640;
    localparam logic [CFG_BITS-1:0] IMG_H_RST  = 12'd480;
    localparam logic [CFG_BITS-1:0] BASE_W_RST = 12'd80;

    // Divide by ten: v * 3277 >> 15 is exact for every 12-bit v
    localparam logic [CFG_BITS-1:0] DIV10_MUL   = 12'd3277;
    localparam int                  DIV10_SHIFT = 15;

    // Operation carried down the compare pipeline
    typedef enum logic [1:0] {
        OP_INIT,
        OP_PAIR,
        OP_REF
    } op_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] img_w;
        logic [CFG_BITS-1:0] img_h;
        logic [CFG_BITS-1:0] base_w;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_cand;
        logic load_ref;
        logic thr_load;
        logic issue;
        op_t  op;
        logic tally;
        logic out_load;
        logic out_empty;
        logic store_clear;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic keep_a;
        logic busy;
        logic out_free;
        logic none_kept;
    } stat_t;

    function automatic logic [CFG_BITS-1:0] div10(input logic [CFG_BITS-1:0] v);
        logic [2*CFG_BITS-1:0] prod;
        prod = (2*CFG_BITS)'(v) * (2*CFG_BITS)'(DIV10_MUL);
        return CFG_BITS'(prod >> DIV10_SHIFT);
    endfunction

endpackage

### design/bosf_overlap.sv
// Two-stage box pair compare: overlap test, width order, size threshold.
// Depends on bosf_pkg.
module bosf_overlap
    import bosf_pkg::*;
#(
    parameter int CW = 12
)
(
    input  logic                clk,
    input  logic [CW-1:0]       a_x,
    input  logic [CW-1:0]       a_y,
    input  logic [CW-1:0]       a_w,
    input  logic [CW-1:0]       a_h,
    input  logic [CW-1:0]       b_x,
    input  logic [CW-1:0]       b_y,
    input  logic [CW-1:0]       b_w,
    input  logic [CW-1:0]       b_h,
    input  logic [CFG_BITS-1:0] thr,
    output logic                hit,
    output logic                a_wider,
    output logic                b_over_thr
);

    localparam int TW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int AW = 2 * CW;
    localparam int PW = 2 * CW + 2;

    logic [CW:0]   a_xe, b_xe, a_ye, b_ye;
    logic [CW:0]   lx, rx, ly, ry;
    logic          apart;

    logic          apart1_reg, apart2_reg;
    logic [CW:0]   sx1_reg, sy1_reg;
    logic [AW-1:0] area_a1_reg, area_b1_reg, area_a2_reg, area_b2_reg;
    logic          wider1_reg, wider2_reg;
    logic          thr1_reg, thr2_reg;
    logic [PW-1:0] common2_reg;

    // Common rectangle edges
    always_comb
    begin
        a_xe  = {1'b0, a_x} + {1'b0, a_w};
        b_xe  = {1'b0, b_x} + {1'b0, b_w};
        a_ye  = {1'b0, a_y} + {1'b0, a_h};
        b_ye  = {1'b0, b_y} + {1'b0, b_h};
        lx    = (a_x > b_x) ? {1'b0, a_x} : {1'b0, b_x};
        ly    = (a_y > b_y) ? {1'b0, a_y} : {1'b0, b_y};
        rx    = (a_xe < b_xe) ? a_xe : b_xe;
        ry    = (a_ye < b_ye) ? a_ye : b_ye;
        apart = (lx > rx) || (ly > ry);
    end

    // Stage 1: spans and areas; stage 2: common area
    always_ff @(posedge clk)
    begin
        apart1_reg  <= apart;
        sx1_reg     <= rx - lx;
        sy1_reg     <= ry - ly;
        area_a1_reg <= AW'(a_w) * AW'(a_h);
        area_b1_reg <= AW'(b_w) * AW'(b_h);
        wider1_reg  <= a_w > b_w;
        thr1_reg    <= TW'(b_w) > TW'(thr);

        apart2_reg  <= apart1_reg;
        common2_reg <= PW'(sx1_reg) * PW'(sy1_reg);
        area_a2_reg <= area_a1_reg;
        area_b2_reg <= area_b1_reg;
        wider2_reg  <= wider1_reg;
        thr2_reg    <= thr1_reg;
    end

    // Overlap when twice the common area beats either box area
    assign hit = !apart2_reg &&
                 (({common2_reg, 1'b0} > (PW+1)'(area_a2_reg)) ||
                  ({common2_reg, 1'b0} > (PW+1)'(area_b2_reg)));
    assign a_wider    = wider2_reg;
    assign b_over_thr = thr2_reg;

endmodule

### design/bosf_datapath.sv
// Datapath: box stores, keep flags, compare pipeline, counters, result register.
// Depends on bosf_pkg and bosf_overlap.
module bosf_datapath
    import bosf_pkg::*;
#(
    parameter int MAX_C = 64,
    parameter int MAX_R = 64,
    parameter int CW    = 12,
    localparam int CIDX = $clog2(MAX_C),
    localparam int RIDX = (MAX_R > 1) ? $clog2(MAX_R) : 1,
    localparam int CCW  = $clog2(MAX_C + 1),
    localparam int RCW  = $clog2(MAX_R + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    input  logic [CIDX-1:0]         addr_a,
    input  logic [CIDX-1:0]         addr_b,
    input  logic [RIDX-1:0]         raddr,
    input  logic [CW-1:0]           box_x,
    input  logic [CW-1:0]           box_y,
    input  logic [CW-1:0]           box_w,
    input  logic [CW-1:0]           box_h,
    output stat_t                   stat,
    output logic [CCW-1:0]          cand_cnt,
    output logic [RCW-1:0]          ref_cnt,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [OUT_BITS-1:0]     out_x,
    output logic [OUT_BITS-1:0]     out_y,
    output logic [OUT_BITS-1:0]     out_w,
    output logic [OUT_BITS-1:0]     out_h,
    output logic                    last,
    output logic                    empty_res,
    output logic [CNT_OUT_BITS-1:0] survivor_count,
    output logic                    overflow
);

    localparam int BW = 4 * CW;

    logic [BW-1:0] cand_mem [MAX_C];
    logic [BW-1:0] ref_mem  [MAX_R];

    logic [BW-1:0]   box_in;
    logic [BW-1:0]   ma_reg, mb_reg, mr_reg, bsel;
    logic            cand_full, ref_full;

    logic [CCW-1:0]  cand_cnt_reg, cand_cnt_next;
    logic [RCW-1:0]  ref_cnt_reg, ref_cnt_next;
    logic            dropped_reg, dropped_next;
    logic [MAX_C-1:0] keep_reg, keep_next;
    logic [CCW-1:0]  surv_cnt_reg, surv_cnt_next;
    logic [CCW-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [CFG_BITS-1:0] thr_reg, thr_next;

    logic            v1_reg, v2_reg, v3_reg;
    op_t             op1_reg, op2_reg, op3_reg;
    logic [CIDX-1:0] ia1_reg, ia2_reg, ia3_reg;
    logic [CIDX-1:0] ib1_reg, ib2_reg, ib3_reg;

    logic            hit, a_wider, b_over_thr;

    logic            res_valid_reg, res_valid_next;
    logic [OUT_BITS-1:0] ox_reg, oy_reg, ow_reg, oh_reg;
    logic            last_reg, empty_reg, ovf_reg;
    logic [CNT_OUT_BITS-1:0] cnt_reg;

    assign box_in    = {box_x, box_y, box_w, box_h};
    assign cand_full = cand_cnt_reg == CCW'(MAX_C);
    assign ref_full  = ref_cnt_reg == RCW'(MAX_R);

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_cand && !cand_full)
            cand_mem[cand_cnt_reg[CIDX-1:0]] <= box_in;
        if (cmd.load_ref && !ref_full)
            ref_mem[ref_cnt_reg[RIDX-1:0]] <= box_in;
        ma_reg <= cand_mem[addr_a];
        mb_reg <= cand_mem[addr_b];
        mr_reg <= ref_mem[raddr];
    end

    // Second box comes from the reference store on reference walks
    assign bsel = (op1_reg == OP_REF) ? mr_reg : mb_reg;

    bosf_overlap #(.CW(CW)) u_ovl (
        .clk        (clk),
        .a_x        (ma_reg[4*CW-1:3*CW]),
        .a_y        (ma_reg[3*CW-1:2*CW]),
        .a_w        (ma_reg[2*CW-1:CW]),
        .a_h        (ma_reg[CW-1:0]),
        .b_x        (bsel[4*CW-1:3*CW]),
        .b_y        (bsel[3*CW-1:2*CW]),
        .b_w        (bsel[2*CW-1:CW]),
        .b_h        (bsel[CW-1:0]),
        .thr        (thr_reg),
        .hit        (hit),
        .a_wider    (a_wider),
        .b_over_thr (b_over_thr)
    );

    // Load counters and overflow flag
    always_comb
    begin
        cand_cnt_next = cand_cnt_reg;
        ref_cnt_next  = ref_cnt_reg;
        dropped_next  = dropped_reg;
        if (cmd.load_cand)
        begin
            if (cand_full)
                dropped_next = 1'b1;
            else
                cand_cnt_next = cand_cnt_reg + CCW'(1);
        end
        if (cmd.load_ref)
        begin
            if (ref_full)
                dropped_next = 1'b1;
            else
                ref_cnt_next = ref_cnt_reg + RCW'(1);
        end
        if (cmd.store_clear)
        begin
            cand_cnt_next = '0;
            ref_cnt_next  = '0;
            dropped_next  = 1'b0;
        end
    end

    // Keep flag updates at pipeline retire
    always_comb
    begin
        keep_next = keep_reg;
        if (v3_reg)
        begin
            case (op3_reg)
                OP_INIT: keep_next[ib3_reg] = b_over_thr;
                OP_PAIR:
                begin
                    if (keep_reg[ib3_reg] && hit)
                    begin
                        if (a_wider)
                            keep_next[ib3_reg] = 1'b0;
                        else
                            keep_next[ia3_reg] = 1'b0;
                    end
                end
                OP_REF:
                begin
                    if (hit)
                        keep_next[ia3_reg] = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Threshold and run counters
    always_comb
    begin
        thr_next      = thr_reg;
        surv_cnt_next = surv_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        if (cmd.thr_load)
        begin
            thr_next = cfg.base_w;
            if (div10(cfg.img_w) > thr_next)
                thr_next = div10(cfg.img_w);
            if (div10(cfg.img_h) > thr_next)
                thr_next = div10(cfg.img_h);
            surv_cnt_next = '0;
            emit_cnt_next = '0;
        end
        if (cmd.tally)
            surv_cnt_next = surv_cnt_reg + CCW'(1);
        if (cmd.out_load)
            emit_cnt_next = emit_cnt_reg + CCW'(1);
    end

    // Result register valid
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.out_load || cmd.out_empty)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_cnt_reg  <= '0;
            ref_cnt_reg   <= '0;
            dropped_reg   <= 1'b0;
            keep_reg      <= '0;
            surv_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cand_cnt_reg  <= cand_cnt_next;
            ref_cnt_reg   <= ref_cnt_next;
            dropped_reg   <= dropped_next;
            keep_reg      <= keep_next;
            surv_cnt_reg  <= surv_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload: threshold, pipeline tags, result fields
    always_ff @(posedge clk)
    begin
        thr_reg <= thr_next;
        op1_reg <= cmd.op;
        ia1_reg <= addr_a;
        ib1_reg <= addr_b;
        op2_reg <= op1_reg;
        ia2_reg <= ia1_reg;
        ib2_reg <= ib1_reg;
        op3_reg <= op2_reg;
        ia3_reg <= ia2_reg;
        ib3_reg <= ib2_reg;
        if (cmd.out_load)
        begin
            ox_reg    <= OUT_BITS'(ma_reg[4*CW-1:3*CW]);
            oy_reg    <= OUT_BITS'(ma_reg[3*CW-1:2*CW]);
            ow_reg    <= OUT_BITS'(ma_reg[2*CW-1:CW]);
            oh_reg    <= OUT_BITS'(ma_reg[CW-1:0]);
            last_reg  <= (emit_cnt_reg + CCW'(1)) == surv_cnt_reg;
            empty_reg <= 1'b0;
            cnt_reg   <= CNT_OUT_BITS'(surv_cnt_reg);
            ovf_reg   <= dropped_reg;
        end
        else if (cmd.out_empty)
        begin
            ox_reg    <= '0;
            oy_reg    <= '0;
            ow_reg    <= '0;
            oh_reg    <= '0;
            last_reg  <= 1'b1;
            empty_reg <= 1'b1;
            cnt_reg   <= '0;
            ovf_reg   <= dropped_reg;
        end
    end

    assign stat.keep_a    = keep_reg[addr_a];
    assign stat.busy      = v1_reg | v2_reg | v3_reg;
    assign stat.out_free  = !res_valid_reg || res_ready;
    assign stat.none_kept = surv_cnt_reg == '0;

    assign cand_cnt       = cand_cnt_reg;
    assign ref_cnt        = ref_cnt_reg;
    assign res_valid      = res_valid_reg;
    assign out_x          = ox_reg;
    assign out_y          = oy_reg;
    assign out_w          = ow_reg;
    assign out_h          = oh_reg;
    assign last           = last_reg;
    assign empty_res      = empty_reg;
    assign survivor_count = cnt_reg;
    assign overflow       = ovf_reg;

endmodule

### design/bosf_ctrl.sv
// Controller: request decode and the pass sequencer of a suppression run.
// Depends on bosf_pkg.
module bosf_ctrl
    import bosf_pkg::*;
#(
    parameter int MAX_C = 64,
    parameter int MAX_R = 64,
    localparam int CIDX = $clog2(MAX_C),
    localparam int RIDX = (MAX_R > 1) ? $clog2(MAX_R) : 1,
    localparam int CCW  = $clog2(MAX_C + 1),
    localparam int RCW  = $clog2(MAX_R + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [1:0]      kind,
    input  stat_t           stat,
    input  logic [CCW-1:0]  cand_cnt,
    input  logic [RCW-1:0]  ref_cnt,
    output cmd_t            cmd,
    output logic [CIDX-1:0] addr_a,
    output logic [CIDX-1:0] addr_b,
    output logic [RIDX-1:0] raddr
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THR,
        ST_INIT,
        ST_INIT_WAIT,
        ST_SUP_CHECK,
        ST_SUP_ISSUE,
        ST_SUP_WAIT,
        ST_REF_CHECK,
        ST_REF_ISSUE,
        ST_REF_WAIT,
        ST_EMIT_CHECK,
        ST_EMIT_LOAD,
        ST_EMPTY,
        ST_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [CCW-1:0] i_reg, i_next;
    logic [CCW-1:0] j_reg, j_next;
    logic [RCW-1:0] r_reg, r_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        cmd        = '0;
        cmd.op     = OP_INIT;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (kind)
                        KIND_CAND:  cmd.load_cand = 1'b1;
                        KIND_REF:   cmd.load_ref  = 1'b1;
                        KIND_START: state_next    = ST_THR;
                        default: ;
                    endcase
                end
            end
            ST_THR:
            begin
                cmd.thr_load = 1'b1;
                j_next       = '0;
                state_next   = ST_INIT;
            end
            // Size test of every candidate
            ST_INIT:
            begin
                if (j_reg == cand_cnt)
                    state_next = ST_INIT_WAIT;
                else
                begin
                    cmd.issue = 1'b1;
                    cmd.op    = OP_INIT;
                    j_next    = j_reg + CCW'(1);
                end
            end
            ST_INIT_WAIT:
            begin
                if (!stat.busy)
                begin
                    i_next     = '0;
                    state_next = ST_SUP_CHECK;
                end
            end
            // Greedy suppression among candidates
            ST_SUP_CHECK:
            begin
                if ((i_reg + CCW'(1)) >= cand_cnt)
                begin
                    i_next     = '0;
                    state_next = ST_REF_CHECK;
                end
                else if (stat.keep_a)
                begin
                    j_next     = i_reg + CCW'(1);
                    state_next = ST_SUP_ISSUE;
                end
                else
                    i_next = i_reg + CCW'(1);
            end
            ST_SUP_ISSUE:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_PAIR;
                j_next    = j_reg + CCW'(1);
                if ((j_reg + CCW'(1)) == cand_cnt)
                    state_next = ST_SUP_WAIT;
            end
            ST_SUP_WAIT:
            begin
                if (!stat.busy)
                begin
                    i_next     = i_reg + CCW'(1);
                    state_next = ST_SUP_CHECK;
                end
            end
            // Survivors against reference boxes, counting what stays
            ST_REF_CHECK:
            begin
                if (i_reg == cand_cnt)
                begin
                    i_next     = '0;
                    state_next = stat.none_kept ? ST_EMPTY : ST_EMIT_CHECK;
                end
                else if (stat.keep_a && (ref_cnt != '0))
                begin
                    r_next     = '0;
                    state_next = ST_REF_ISSUE;
                end
                else
                begin
                    cmd.tally = stat.keep_a;
                    i_next    = i_reg + CCW'(1);
                end
            end
            ST_REF_ISSUE:
            begin
                cmd.issue = 1'b1;
                cmd.op    = OP_REF;
                r_next    = r_reg + RCW'(1);
                if ((r_reg + RCW'(1)) == ref_cnt)
                    state_next = ST_REF_WAIT;
            end
            ST_REF_WAIT:
            begin
                if (!stat.busy)
                begin
                    cmd.tally  = stat.keep_a;
                    i_next     = i_reg + CCW'(1);
                    state_next = ST_REF_CHECK;
                end
            end
            // Emit survivors in load order
            ST_EMIT_CHECK:
            begin
                if (i_reg == cand_cnt)
                    state_next = ST_DONE;
                else if (stat.keep_a)
                    state_next = ST_EMIT_LOAD;
                else
                    i_next = i_reg + CCW'(1);
            end
            ST_EMIT_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    i_next       = i_reg + CCW'(1);
                    state_next   = ST_EMIT_CHECK;
                end
            end
            ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.store_clear = 1'b1;
                state_next      = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
        end
    end

    assign req_ready = state_reg == ST_IDLE;
    assign addr_a    = i_reg[CIDX-1:0];
    assign addr_b    = j_reg[CIDX-1:0];
    assign raddr     = r_reg[RIDX-1:0];

endmodule

### design/box_overlap_suppression_filter_core.sv
// Top level of the box overlap suppression filter: register port and glue.
// Depends on bosf_pkg, bosf_ctrl and bosf_datapath.
//
//   channel   signals                                   direction
//   -------   ---------------------------------------   ---------
//   config    psel penable pwrite paddr pwdata prdata    slave
//   request   req_valid req_ready kind box_x..box_h      sink
//   result    res_valid res_ready out_x..overflow        source
//
// Loads are taken only while idle; kind 3 requests are taken and ignored.
// A start loads the threshold, runs the size test of every candidate, then the
// pair walk of each kept candidate below N-1 against the later ones and the
// reference walk of each candidate still kept when R > 0, then emits one result
// per survivor, or one empty result when nothing survives. The single compare
// pipeline takes one pair per cycle.
// Reset clears counts, flags and the result valid flag; stores need no clearing.
// A stalled result register holds the sequencer; requests wait until idle.
module box_overlap_suppression_filter_core
    import bosf_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int MAX_REFERENCES = 64,
    parameter int COORD_BITS     = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [1:0]              kind,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [COORD_BITS-1:0]   box_w,
    input  logic [COORD_BITS-1:0]   box_h,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [OUT_BITS-1:0]     out_x,
    output logic [OUT_BITS-1:0]     out_y,
    output logic [OUT_BITS-1:0]     out_w,
    output logic [OUT_BITS-1:0]     out_h,
    output logic                    last,
    output logic                    empty_res,
    output logic [CNT_OUT_BITS-1:0] survivor_count,
    output logic                    overflow
);

    localparam int CIDX = $clog2(MAX_CANDIDATES);
    localparam int RIDX = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
    localparam int CCW  = $clog2(MAX_CANDIDATES + 1);
    localparam int RCW  = $clog2(MAX_REFERENCES + 1);

    cfg_t            cfg_reg, cfg_next;
    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    cmd_t            cmd;
    stat_t           stat;
    logic [CIDX-1:0] addr_a, addr_b;
    logic [RIDX-1:0] raddr;
    logic [CCW-1:0]  cand_cnt;
    logic [RCW-1:0]  ref_cnt;

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_IMG_W:  cfg_next.img_w  = pwdata[CFG_BITS-1:0];
                REG_IMG_H:  cfg_next.img_h  = pwdata[CFG_BITS-1:0];
                REG_BASE_W: cfg_next.base_w = pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMG_W:  prdata = APB_DW'(cfg_reg.img_w);
            REG_IMG_H:  prdata = APB_DW'(cfg_reg.img_h);
            REG_BASE_W: prdata = APB_DW'(cfg_reg.base_w);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.img_w  <= IMG_W_RST;
            cfg_reg.img_h  <= IMG_H_RST;
            cfg_reg.base_w <= BASE_W_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Sequencer
    bosf_ctrl #(
        .MAX_C (MAX_CANDIDATES),
        .MAX_R (MAX_REFERENCES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .stat      (stat),
        .cand_cnt  (cand_cnt),
        .ref_cnt   (ref_cnt),
        .cmd       (cmd),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .raddr     (raddr)
    );

    // Stores, compare pipeline and result register
    bosf_datapath #(
        .MAX_C (MAX_CANDIDATES),
        .MAX_R (MAX_REFERENCES),
        .CW    (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .addr_a         (addr_a),
        .addr_b         (addr_b),
        .raddr          (raddr),
        .box_x          (box_x),
        .box_y          (box_y),
        .box_w          (box_w),
        .box_h          (box_h),
        .stat           (stat),
        .cand_cnt       (cand_cnt),
        .ref_cnt        (ref_cnt),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_w          (out_w),
        .out_h          (out_h),
        .last           (last),
        .empty_res      (empty_res),
        .survivor_count (survivor_count),
        .overflow       (overflow)
    );

    // An empty result closes its run and reports no survivors
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && empty_res |-> last && (survivor_count == '0))
        else $error("empty result without last mark or with survivors");

    // The compare pipeline is drained whenever requests are taken
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !stat.busy)
        else $error("compare pipeline busy while idle");

    // The candidate count never runs past the store depth
    a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cand_cnt <= CCW'(MAX_CANDIDATES))
        else $error("candidate count beyond store depth");

endmodule
